>>> sv/assert_macros.svh
// Assertion macros shared by the RTL of the identifier lexer.
// No dependencies; take in by include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define CIL_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("lexer assertion failed");
// expression must never be true out of reset
`define CIL_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("lexer forbidden condition seen");
`else
`define CIL_ASSERT(lbl, clk, rstn, prop)
`define CIL_NEVER(lbl, clk, rstn, expr)
`endif
`endif

>>> sv/cil_pkg.sv
// Package for the C identifier lexer: constants, character classes, types.
// No dependencies.
package cil_pkg;

  localparam int MAX_TOKEN_CHARS_DEF = 31;
  localparam int MAX_NEST_DEPTH_DEF  = 15;
  localparam int POS_W               = 5;
  localparam int QUEUE_DEPTH         = 2;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;

  localparam logic [7:0] INCLUDE_WORD [8] = '{8'h23, 8'h69, 8'h6E, 8'h63,
                                              8'h6C, 8'h75, 8'h64, 8'h65};

  typedef enum logic {DR_IDLE, DR_RUN} drain_state_t;

  // back end status seen by the front end
  typedef struct packed {
    logic active;  // a token is being drained
    logic done;    // last read of a bank issued this cycle
    logic bank;
  } drain_stat_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

endpackage

>>> sv/c_identifier_lexer_top.sv
// Top level of the C identifier lexer: front end, descriptor queue, back end, store.
// Depends on cil_pkg, cil_ram, cil_front, cil_queue, cil_back, assert_macros.svh.
//
//  channel | direction | handshake            | payload
//  in_     | in        | in_valid / in_ready   | source_byte[7:0], end_of_file
//  out_    | out       | out_valid / out_ready | token_char[7:0], char_position[4:0],
//          |           |                       | last_of_token
//  cfg_    | in        | cfg_valid / cfg_ready | nested_comments
//
// One source byte is taken per cycle. A kept token is presented once its descriptor has
// passed the queue and the back end, one character per cycle while out_ready is high; the
// back end returns to its idle state to fetch a descriptor between tokens drained back to back.
// Input stalls only while both store banks hold tokens not yet read out.
// Reset is synchronous: lexer state clears and comments become flat.
`include "assert_macros.svh"
module c_identifier_lexer_top import cil_pkg::*; #(
  parameter int MAX_TOKEN_CHARS = MAX_TOKEN_CHARS_DEF,
  parameter int MAX_NEST_DEPTH  = MAX_NEST_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_source_byte,
  input  logic             in_end_of_file,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_token_char,
  output logic [POS_W-1:0] out_char_position,
  output logic             out_last_of_token,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_nested_comments
);

  localparam int LW = $clog2(MAX_TOKEN_CHARS + 1);
  localparam int IW = $clog2(MAX_TOKEN_CHARS);

  logic          wr_en, rd_en;
  logic [IW:0]   wr_addr, rd_addr;
  logic [7:0]    wr_data;
  logic          q_push, q_pop, q_empty, q_full;
  logic [LW:0]   q_wdata, q_rdata;
  logic [1:0]    busy;
  drain_stat_t   drain_stat;

  cil_front #(
    .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS),
    .MAX_NEST_DEPTH  (MAX_NEST_DEPTH)
  ) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_source_byte      (in_source_byte),
    .in_end_of_file      (in_end_of_file),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_nested_comments (cfg_nested_comments),
    .wr_en               (wr_en),
    .wr_addr             (wr_addr),
    .wr_data             (wr_data),
    .q_push              (q_push),
    .q_wdata             (q_wdata),
    .drain_stat          (drain_stat),
    .busy                (busy)
  );

  cil_ram #(
    .WIDTH (8),
    .DEPTH (2 * (2 ** IW))
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (out_token_char)
  );

  cil_queue #(
    .WIDTH (LW + 1),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full)
  );

  cil_back #(
    .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_rdata           (q_rdata),
    .q_pop             (q_pop),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr),
    .drain_stat        (drain_stat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_char_position (out_char_position),
    .out_last_of_token (out_last_of_token)
  );

  // each busy bank has exactly one descriptor queued or in drain
  `CIL_NEVER(a_queue_overflow, clk, rst_n, q_push && q_full && !q_pop)
  `CIL_ASSERT(a_release_busy, clk, rst_n, drain_stat.done |-> busy[drain_stat.bank])
  `CIL_ASSERT(a_stall_cause, clk, rst_n, !in_ready |-> (!q_empty || drain_stat.active))
  `CIL_NEVER(a_write_read_clash, clk, rst_n, wr_en && rd_en && (wr_addr[IW] == rd_addr[IW]))

endmodule

>>> sv/cil_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
module cil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/cil_front.sv
// Front end: comment/quote/escape filter, token collection into a banked store,
// keep decision and descriptor push. Depends on cil_pkg.
module cil_front import cil_pkg::*; #(
  parameter int MAX_TOKEN_CHARS = MAX_TOKEN_CHARS_DEF,
  parameter int MAX_NEST_DEPTH  = MAX_NEST_DEPTH_DEF,
  localparam int LW = $clog2(MAX_TOKEN_CHARS + 1),
  localparam int IW = $clog2(MAX_TOKEN_CHARS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_source_byte,
  input  logic          in_end_of_file,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_nested_comments,
  output logic          wr_en,
  output logic [IW:0]   wr_addr,
  output logic [7:0]    wr_data,
  output logic          q_push,
  output logic [LW:0]   q_wdata,
  input  drain_stat_t   drain_stat,
  output logic [1:0]    busy
);

  localparam int DW = $clog2(MAX_NEST_DEPTH + 1);

  logic          nested_r;
  logic          esc_r, esc_nxt;
  logic          dq_r, dq_nxt;
  logic          sq_r, sq_nxt;
  logic          slash_r, slash_nxt;
  logic          star_r, star_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic          coll_r, coll_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [7:0]    first_r, first_nxt;
  logic          match_r, match_nxt;
  logic          wbank_r, wbank_nxt;
  logic [1:0]    busy_r, busy_nxt;

  logic       in_fire;
  logic       pass, blocked, finish, keep;
  logic [7:0] c;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = !busy_r[wbank_r];
  assign cfg_ready = 1'b1;
  assign c         = in_source_byte;
  assign busy      = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nested_r <= 1'b0;
    end else if (cfg_valid) begin
      nested_r <= cfg_nested_comments;
    end
  end

  // filter
  always_comb begin
    esc_nxt   = esc_r;
    dq_nxt    = dq_r;
    sq_nxt    = sq_r;
    slash_nxt = slash_r;
    star_nxt  = star_r;
    depth_nxt = depth_r;
    pass      = 1'b0;
    blocked   = 1'b0;
    if (esc_r) begin
      esc_nxt = 1'b0;
    end else if (c == CH_BSLASH) begin
      esc_nxt = 1'b1;
    end else begin
      if (!dq_r && !sq_r) begin
        if (c == CH_STAR && depth_r != '0 && !slash_r) begin
          star_nxt = 1'b1;
          blocked  = 1'b1;
        end else if (c == CH_SLASH && star_r) begin
          if (depth_r != '0) depth_nxt = depth_r - 1'b1;
          star_nxt = 1'b0;
          blocked  = 1'b1;
        end else begin
          star_nxt = 1'b0;
          if (c == CH_SLASH) begin
            slash_nxt = 1'b1;
            blocked   = 1'b1;
          end else if (c == CH_STAR && slash_r) begin
            if (!nested_r) begin
              depth_nxt = DW'(1);
            end else if (depth_r < DW'(MAX_NEST_DEPTH)) begin
              depth_nxt = depth_r + 1'b1;
            end
            slash_nxt = 1'b0;
            blocked   = 1'b1;
          end else begin
            slash_nxt = 1'b0;
            if (depth_r != '0) blocked = 1'b1;
          end
        end
      end
      if (!blocked) begin
        if (c == CH_DQUOTE && !sq_r) begin
          dq_nxt = !dq_r;
        end else if (!dq_r) begin
          if (c == CH_SQUOTE) begin
            sq_nxt = !sq_r;
          end else if (!sq_r) begin
            pass = 1'b1;
          end
        end
      end
    end
  end

  // a '#' token survives only as exactly "#include"; '0' tokens never survive
  assign keep = coll_r && (first_r != CH_ZERO) &&
                ((first_r != CH_HASH) || (len_r == LW'(8) && match_r));

  always_comb begin
    coll_nxt  = coll_r;
    len_nxt   = len_r;
    first_nxt = first_r;
    match_nxt = match_r;
    wbank_nxt = wbank_r;
    busy_nxt  = busy_r;
    finish    = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = {wbank_r, len_r[IW-1:0]};
    wr_data   = c;
    if (drain_stat.done) busy_nxt[drain_stat.bank] = 1'b0;
    if (in_fire) begin
      if (in_end_of_file) begin
        finish = 1'b1;
      end else if (pass) begin
        if (!coll_r) begin
          if (is_letter(c) || c == CH_UNDER || c == CH_ZERO || c == CH_HASH) begin
            wr_en     = 1'b1;
            wr_addr   = {wbank_r, {IW{1'b0}}};
            first_nxt = c;
            len_nxt   = LW'(1);
            coll_nxt  = 1'b1;
            match_nxt = (c == CH_HASH);
          end
        end else if (is_letter(c) || is_digit(c) || c == CH_UNDER) begin
          if (len_r < LW'(MAX_TOKEN_CHARS)) begin
            wr_en   = 1'b1;
            len_nxt = len_r + 1'b1;
            if (len_r < LW'(8)) begin
              match_nxt = match_r && (c == INCLUDE_WORD[len_r[2:0]]);
            end
          end
        end else begin
          finish = 1'b1;
        end
      end
    end
    if (finish) begin
      coll_nxt = 1'b0;
      len_nxt  = '0;
      if (keep) begin
        busy_nxt[wbank_r] = 1'b1;
        wbank_nxt         = !wbank_r;
      end
    end
  end

  assign q_push  = finish && keep;
  assign q_wdata = {wbank_r, len_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r   <= 1'b0;
      dq_r    <= 1'b0;
      sq_r    <= 1'b0;
      slash_r <= 1'b0;
      star_r  <= 1'b0;
      depth_r <= '0;
      coll_r  <= 1'b0;
      len_r   <= '0;
      match_r <= 1'b0;
      wbank_r <= 1'b0;
      busy_r  <= '0;
    end else begin
      coll_r  <= coll_nxt;
      len_r   <= len_nxt;
      match_r <= match_nxt;
      wbank_r <= wbank_nxt;
      busy_r  <= busy_nxt;
      if (in_fire && in_end_of_file) begin
        esc_r   <= 1'b0;
        dq_r    <= 1'b0;
        sq_r    <= 1'b0;
        slash_r <= 1'b0;
        star_r  <= 1'b0;
        depth_r <= '0;
      end else if (in_fire) begin
        esc_r   <= esc_nxt;
        dq_r    <= dq_nxt;
        sq_r    <= sq_nxt;
        slash_r <= slash_nxt;
        star_r  <= star_nxt;
        depth_r <= depth_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
  end

endmodule

>>> sv/cil_queue.sv
// Small register queue carrying token descriptors from front to back end.
// Depends on cil_pkg.
module cil_queue import cil_pkg::*; #(
  parameter int WIDTH = 7,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic             full
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PW-1:0]    wptr_r, rptr_r;
  logic [PW:0]      cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (PW+1)'(DEPTH));
  assign rdata = entry_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wptr_r] <= wdata;
  end

endmodule

>>> sv/cil_back.sv
// Back end: takes token descriptors and reads the characters out of the store, one per cycle
// while out_ready allows; the RAM read register is the output register. Depends on cil_pkg.
module cil_back import cil_pkg::*; #(
  parameter int MAX_TOKEN_CHARS = MAX_TOKEN_CHARS_DEF,
  localparam int LW = $clog2(MAX_TOKEN_CHARS + 1),
  localparam int IW = $clog2(MAX_TOKEN_CHARS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  logic [LW:0]      q_rdata,
  output logic             q_pop,
  output logic             rd_en,
  output logic [IW:0]      rd_addr,
  output drain_stat_t      drain_stat,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [POS_W-1:0] out_char_position,
  output logic             out_last_of_token
);

  drain_state_t     state_r, state_nxt;
  logic [LW-1:0]    idx_r, idx_nxt;
  logic [LW-1:0]    len_r, len_nxt;
  logic             bank_r, bank_nxt;
  logic             ov_r, ov_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             lastf_r, lastf_nxt;
  logic             is_last;

  assign is_last = (idx_r + 1'b1 == len_r);
  assign rd_addr = {bank_r, idx_r[IW-1:0]};

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    bank_nxt  = bank_r;
    ov_nxt    = ov_r;
    pos_nxt   = pos_r;
    lastf_nxt = lastf_r;
    q_pop     = 1'b0;
    rd_en     = 1'b0;
    drain_stat.active = (state_r == DR_RUN);
    drain_stat.done   = 1'b0;
    drain_stat.bank   = bank_r;
    if (out_ready) ov_nxt = 1'b0;
    case (state_r)
      DR_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          bank_nxt  = q_rdata[LW];
          len_nxt   = q_rdata[LW-1:0];
          idx_nxt   = '0;
          state_nxt = DR_RUN;
        end
      end
      DR_RUN: begin
        if (!ov_r || out_ready) begin
          rd_en     = 1'b1;
          ov_nxt    = 1'b1;
          pos_nxt   = POS_W'(idx_r);
          lastf_nxt = is_last;
          idx_nxt   = idx_r + 1'b1;
          if (is_last) begin
            drain_stat.done = 1'b1;
            state_nxt       = DR_IDLE;
          end
        end
      end
      default: state_nxt = DR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DR_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    len_r   <= len_nxt;
    bank_r  <= bank_nxt;
    pos_r   <= pos_nxt;
    lastf_r <= lastf_nxt;
  end

  assign out_valid         = ov_r;
  assign out_char_position = pos_r;
  assign out_last_of_token = lastf_r;

endmodule

>>> tb/c_identifier_lexer_top_test.sv
// Self-checking testbench for c_identifier_lexer_top: directed table, then random C-like text.
// Depends on cil_pkg and the lexer RTL; results are checked against a predictor held here.
module c_identifier_lexer_top_test import cil_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS   = 55;

  typedef struct packed {
    logic [7:0]       ch;
    logic [POS_W-1:0] pos;
    logic             last;
  } token_char_t;

  // one row of the directed table; word is the pinned token, right aligned
  typedef struct packed {
    logic [7:0]  src;
    logic        eof;
    logic        pinned;
    logic [63:0] word;
  } dir_row_t;

  typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_mode_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [7:0]       in_source_byte;
  logic             in_end_of_file;
  logic             out_valid;
  logic             out_ready;
  logic [7:0]       out_token_char;
  logic [POS_W-1:0] out_char_position;
  logic             out_last_of_token;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_nested_comments;

  c_identifier_lexer_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_source_byte     (in_source_byte),
    .in_end_of_file     (in_end_of_file),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_token_char     (out_token_char),
    .out_char_position  (out_char_position),
    .out_last_of_token  (out_last_of_token),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_nested_comments(cfg_nested_comments)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor state
  logic        nest_mode = 1'b0;
  logic        esc_pend = 1'b0;
  logic        in_dq = 1'b0;
  logic        in_sq = 1'b0;
  logic        slash_mark = 1'b0;
  logic        star_mark = 1'b0;
  logic        collecting = 1'b0;
  int unsigned depth = 0;
  int          tok_len = 0;
  logic [7:0]  tok_buf [MAX_TOKEN_CHARS_DEF];

  token_char_t lexed_now [$];
  token_char_t token_chars_due [$];
  int          mismatch_count = 0;

  logic        row_pinned = 1'b0;
  logic [63:0] row_word = '0;

  function automatic bit starts_token(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == CH_UNDER ||
           c == CH_ZERO || c == CH_HASH;
  endfunction

  function automatic bit continues_token(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9") ||
           c == CH_UNDER;
  endfunction

  // strips escapes, comments and quoted text; 1 when the byte reaches the lexer
  function automatic bit filter_keeps(logic [7:0] c);
    if (esc_pend) begin
      esc_pend = 1'b0;
      return 1'b0;
    end
    if (c == CH_BSLASH) begin
      esc_pend = 1'b1;
      return 1'b0;
    end
    if (!in_dq && !in_sq) begin
      if (c == CH_STAR && depth != 0 && !slash_mark) begin
        star_mark = 1'b1;
        return 1'b0;
      end
      if (c == CH_SLASH && star_mark) begin
        if (depth != 0) depth--;
        star_mark = 1'b0;
        return 1'b0;
      end
      star_mark = 1'b0;
      if (c == CH_SLASH) begin
        slash_mark = 1'b1;
        return 1'b0;
      end
      if (c == CH_STAR && slash_mark) begin
        if (!nest_mode) depth = 1;
        else if (depth < MAX_NEST_DEPTH_DEF) depth++;
        slash_mark = 1'b0;
        return 1'b0;
      end
      slash_mark = 1'b0;
      if (depth != 0) return 1'b0;
    end
    if (c == CH_DQUOTE && !in_sq) begin
      in_dq = !in_dq;
      return 1'b0;
    end
    if (in_dq) return 1'b0;
    if (c == CH_SQUOTE) begin
      in_sq = !in_sq;
      return 1'b0;
    end
    return !in_sq;
  endfunction

  function automatic void close_token();
    bit keep;
    keep = collecting && tok_len != 0;
    if (keep && tok_buf[0] == CH_ZERO) keep = 1'b0;
    if (keep && tok_buf[0] == CH_HASH) begin
      keep = (tok_len == 8);
      for (int k = 0; k < 8; k++)
        if (keep && tok_buf[k] != INCLUDE_WORD[k]) keep = 1'b0;
    end
    if (keep)
      for (int k = 0; k < tok_len; k++)
        lexed_now.push_back('{ch: tok_buf[k], pos: POS_W'(k), last: (k + 1 == tok_len)});
    collecting = 1'b0;
    tok_len = 0;
  endfunction

  function automatic void lex_item(logic [7:0] c, logic eof);
    if (eof) begin
      close_token();
      esc_pend = 1'b0;
      in_dq = 1'b0;
      in_sq = 1'b0;
      slash_mark = 1'b0;
      star_mark = 1'b0;
      depth = 0;
      return;
    end
    if (!filter_keeps(c)) return;
    if (!collecting) begin
      if (starts_token(c)) begin
        tok_buf[0] = c;
        tok_len = 1;
        collecting = 1'b1;
      end
      return;
    end
    if (continues_token(c)) begin
      // over-long tokens keep their first characters only
      if (tok_len < MAX_TOKEN_CHARS_DEF) begin
        tok_buf[tok_len] = c;
        tok_len++;
      end
      return;
    end
    close_token();
  endfunction

  function automatic void queue_word(logic [63:0] w);
    int top;
    top = -1;
    for (int k = 0; k < 8; k++)
      if (w[8*k +: 8] != 8'h00) top = k;
    for (int k = top; k >= 0; k--)
      token_chars_due.push_back('{ch: w[8*k +: 8], pos: POS_W'(top - k), last: (k == 0)});
  endfunction

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin : monitor
    token_char_t due;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        lexed_now.delete();
        lex_item(in_source_byte, in_end_of_file);
        if (row_pinned) queue_word(row_word);
        else foreach (lexed_now[i]) token_chars_due.push_back(lexed_now[i]);
      end
      if (cfg_valid && cfg_ready) nest_mode = cfg_nested_comments;
      if (out_valid && out_ready) begin
        if (token_chars_due.size() == 0) begin
          $error("token_char: no transaction expected, got %h", out_token_char);
          mismatch_count++;
        end else begin
          due = token_chars_due.pop_front();
          if (out_token_char !== due.ch) begin
            $error("token_char: expected %h, got %h", due.ch, out_token_char);
            mismatch_count++;
          end
          if (out_char_position !== due.pos) begin
            $error("char_position: expected %0d, got %0d", due.pos, out_char_position);
            mismatch_count++;
          end
          if (out_last_of_token !== due.last) begin
            $error("last_of_token: expected %b, got %b", due.last, out_last_of_token);
            mismatch_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  rx_mode_t rx_mode = RX_STEADY;
  int       rx_left = 0;
  int       rx_hold = 0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(8, 80);
    end
    rx_left--;
    case (rx_mode)
      RX_STEADY: out_ready <= 1'b1;
      RX_COIN:   out_ready <= $urandom_range(0, 1);
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default: begin
        // long stalls with a single ready cycle between them
        if (rx_hold == 0) begin
          rx_hold = $urandom_range(1, 20);
          out_ready <= 1'b1;
        end else begin
          rx_hold--;
          out_ready <= 1'b0;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------- sender
  int burst_left = 0;
  logic [8:0] seg_q [$];  // {end_of_file, source_byte}

  dir_row_t directed_rows [25] = '{
    '{CH_HASH,   1'b0, 1'b0, 64'h0},
    '{"i",       1'b0, 1'b0, 64'h0},
    '{"n",       1'b0, 1'b0, 64'h0},
    '{"c",       1'b0, 1'b0, 64'h0},
    '{"l",       1'b0, 1'b0, 64'h0},
    '{"u",       1'b0, 1'b0, 64'h0},
    '{"d",       1'b0, 1'b0, 64'h0},
    '{"e",       1'b0, 1'b0, 64'h0},
    '{8'h00,     1'b0, 1'b1, "#include"},  // byte zero ends the token
    '{CH_ZERO,   1'b0, 1'b0, 64'h0},
    '{"x",       1'b0, 1'b0, 64'h0},
    '{8'hFF,     1'b0, 1'b1, 64'h0},       // number dropped, top byte is a delimiter
    '{CH_UNDER,  1'b0, 1'b0, 64'h0},
    '{"Z",       1'b0, 1'b0, 64'h0},
    '{"9",       1'b0, 1'b0, 64'h0},
    '{8'hFF,     1'b1, 1'b1, "_Z9"},       // end of file flushes
    '{CH_SLASH,  1'b0, 1'b0, 64'h0},
    '{CH_STAR,   1'b0, 1'b0, 64'h0},
    '{CH_STAR,   1'b0, 1'b0, 64'h0},
    '{CH_BSLASH, 1'b0, 1'b0, 64'h0},       // escape keeps the pending star
    '{"x",       1'b0, 1'b0, 64'h0},
    '{CH_SLASH,  1'b0, 1'b0, 64'h0},
    '{"a",       1'b0, 1'b0, 64'h0},
    '{8'h00,     1'b1, 1'b1, "a"},
    '{8'h5A,     1'b1, 1'b1, 64'h0}
  };

  task automatic gap_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic pace();
    if (burst_left == 0) begin
      gap_cycles($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    burst_left--;
  endtask

  task automatic send_byte(logic [7:0] b, logic eof, logic pinned, logic [63:0] word);
    @(negedge clk);
    in_valid <= 1'b1;
    in_source_byte <= b;
    in_end_of_file <= eof;
    row_pinned = pinned;
    row_word = word;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold input until every expected character has drained, then let the pipe empty
  task automatic settle();
    do gap_cycles(1); while (token_chars_due.size() != 0);
    gap_cycles(SETTLE_CYCLES);
  endtask

  task automatic write_nesting(logic v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_nested_comments <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_letter();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("A" + r);
    if (r < 52) return 8'("a" + r - 26);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] pick_body();
    if ($urandom_range(0, 5) == 0) return 8'("0" + $urandom_range(0, 9));
    return pick_letter();
  endfunction

  function automatic logic [7:0] pick_sep();
    case ($urandom_range(0, 9))
      0: return " ";
      1: return 8'h0A;
      2: return ";";
      3: return "(";
      4: return ")";
      5: return ",";
      6: return "=";
      7: return 8'h00;
      8: return 8'($urandom_range(128, 255));
      default: return "+";
    endcase
  endfunction

  function automatic logic [7:0] pick_inner();
    case ($urandom_range(0, 7))
      0: return CH_STAR;
      1: return CH_SLASH;
      2: return CH_BSLASH;
      3: return CH_SQUOTE;
      4: return pick_sep();
      default: return pick_letter();
    endcase
  endfunction

  function automatic void push_byte(logic [7:0] b);
    seg_q.push_back({1'b0, b});
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  // one fragment of C-like text; mostly well formed, some noise
  function automatic void build_segment();
    int kind;
    int n;
    seg_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      push_byte(pick_letter());
      repeat ($urandom_range(0, 7)) push_byte(pick_body());
      push_byte(pick_sep());
    end else if (kind < 34) begin
      push_byte(pick_letter());
      repeat ($urandom_range(27, 40)) push_byte(pick_body());
      push_byte(pick_sep());
    end else if (kind < 40) begin
      push_byte(CH_ZERO);
      repeat ($urandom_range(0, 4)) push_byte(pick_body());
      push_byte(pick_sep());
    end else if (kind < 48) begin
      case ($urandom_range(0, 4))
        0, 1: push_text("#include");
        2: push_text("#includ");
        3: push_text("#includes");
        default: push_text("#define");
      endcase
      push_byte(pick_sep());
    end else if (kind < 60) begin
      push_text("/*");
      repeat ($urandom_range(0, 6)) push_byte(pick_inner());
      push_text("*/");
    end else if (kind < 64) begin
      n = $urandom_range(12, 18);
      repeat (n) push_text("/*");
      push_byte(pick_letter());
      repeat (n) push_text("*/");
      push_byte(pick_sep());
    end else if (kind < 72) begin
      push_byte(CH_DQUOTE);
      repeat ($urandom_range(0, 5)) push_byte(pick_inner());
      push_byte(CH_DQUOTE);
    end else if (kind < 78) begin
      push_byte(CH_SQUOTE);
      if ($urandom_range(0, 2) == 0) push_byte(CH_BSLASH);
      push_byte(8'($urandom_range(32, 126)));
      push_byte(CH_SQUOTE);
    end else if (kind < 84) begin
      push_byte(CH_BSLASH);
      push_byte(8'($urandom_range(0, 255)));
    end else if (kind < 97) begin
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
    end else begin
      seg_q.push_back({1'b1, 8'($urandom_range(0, 255))});
    end
  endfunction

  logic phase_nesting [3] = '{1'b1, 1'b0, 1'b1};

  initial begin
    int sent;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_source_byte = 8'h00;
    in_end_of_file = 1'b0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_nested_comments = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed rows run with the reset setting: flat comments
    foreach (directed_rows[i]) begin
      pace();
      send_byte(directed_rows[i].src, directed_rows[i].eof, directed_rows[i].pinned,
                directed_rows[i].word);
    end

    foreach (phase_nesting[p]) begin
      settle();
      write_nesting(phase_nesting[p]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_segment();
        foreach (seg_q[i]) begin
          pace();
          send_byte(seg_q[i][7:0], seg_q[i][8], 1'b0, 64'h0);
          sent++;
        end
        if ($urandom_range(0, 49) == 0) settle();
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
